### sv/dbfifo_pkg.sv
// Shared types and constants for the dual byte FIFO with drop-oldest overflow.
// Used by dbfifo_ring and dual_byte_fifo_drop_oldest_top. No dependencies.
`default_nettype none

package dbfifo_pkg;

  // Ring sizing: a requested depth below MinDepth is raised to MinDepth.
  localparam int unsigned DefDepth = 256;
  localparam int unsigned MinDepth = 64;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 8;
  localparam int unsigned CountW = 32;
  localparam int unsigned OpW    = 3;

  // Operation codes.
  localparam logic [OpW-1:0] OP_PUSH_RX   = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_TX   = 3'd1;
  localparam logic [OpW-1:0] OP_READ_RX   = 3'd2;
  localparam logic [OpW-1:0] OP_PEEK_RX   = 3'd3;
  localparam logic [OpW-1:0] OP_READ_TX   = 3'd4;
  localparam logic [OpW-1:0] OP_CLEAR_RX  = 3'd5;
  localparam logic [OpW-1:0] OP_CLEAR_TX  = 3'd6;
  localparam logic [OpW-1:0] OP_CLEAR_ALL = 3'd7;

  // Command to one ring for one transaction.
  typedef struct packed {
    logic push;
    logic take;
    logic consume;
    logic clear;
    logic clear_cnt;
  } ring_cmd_t;

  // Status of one ring, reflecting the last accepted transaction.
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [CountW-1:0] pushed;
    logic [CountW-1:0] dropped;
  } ring_stat_t;

endpackage

`default_nettype wire

### sv/dual_byte_fifo_drop_oldest_top.sv
// Top level of the dual byte FIFO (receive and transmit rings, drop oldest).
// Depends on dbfifo_pkg, dbfifo_ring and dbfifo_ram.
`default_nettype none

// Two byte rings, receive and transmit, each holding up to depth-1 bytes (depth
// is raised to at least 64). Every transaction carries one operation and gives
// exactly one result: the byte read or peeked with its valid flag (data zero
// when not valid), both fill levels (saturated at 255) and the four 32-bit
// wrapping push and drop counters as they stand after the operation. A push into
// a full ring drops the oldest byte and counts it. Clearing a ring resets its
// pointers; clear-all also zeroes the counters. The byte stores are synchronous
// RAMs with registered read data, so each transaction passes a work stage
// (RAM read in flight, pointers already updated) and then an output register,
// and with the output taken promptly one transaction is accepted every cycle.
// The store contents come up undefined; the pointers never let an unwritten
// slot be read.
module dual_byte_fifo_drop_oldest_top #(
  parameter int unsigned RX_DEPTH = dbfifo_pkg::DefDepth,
  parameter int unsigned TX_DEPTH = dbfifo_pkg::DefDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [dbfifo_pkg::OpW-1:0]        operation_i,
  input  wire logic [dbfifo_pkg::ByteW-1:0]      data_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   read_valid_o,
  output logic      [dbfifo_pkg::ByteW-1:0]      read_data_o,
  output logic      [dbfifo_pkg::LevelW-1:0]     rx_level_o,
  output logic      [dbfifo_pkg::LevelW-1:0]     tx_level_o,
  output logic      [dbfifo_pkg::CountW-1:0]     rx_pushed_o,
  output logic      [dbfifo_pkg::CountW-1:0]     rx_dropped_o,
  output logic      [dbfifo_pkg::CountW-1:0]     tx_pushed_o,
  output logic      [dbfifo_pkg::CountW-1:0]     tx_dropped_o
);

  dbfifo_pkg::ring_cmd_t  rx_cmd, tx_cmd;
  dbfifo_pkg::ring_stat_t rx_stat, tx_stat;
  logic                   rx_take_ok, tx_take_ok;
  logic [dbfifo_pkg::ByteW-1:0] rx_rdata, tx_rdata;

  logic accept, move;

  // Work stage: one transaction whose RAM read (if any) is in flight.
  logic work_valid_q, work_valid_d;
  logic work_rd_q, work_tx_q;

  // Output register.
  logic out_valid_q, out_valid_d;

  assign move       = work_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !work_valid_q || move;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the operation into per-ring commands.
  always_comb begin
    rx_cmd = '0;
    tx_cmd = '0;
    if (accept) begin
      case (operation_i)
        dbfifo_pkg::OP_PUSH_RX: rx_cmd.push = 1'b1;
        dbfifo_pkg::OP_PUSH_TX: tx_cmd.push = 1'b1;
        dbfifo_pkg::OP_READ_RX: begin
          rx_cmd.take    = 1'b1;
          rx_cmd.consume = 1'b1;
        end
        dbfifo_pkg::OP_PEEK_RX: rx_cmd.take = 1'b1;
        dbfifo_pkg::OP_READ_TX: begin
          tx_cmd.take    = 1'b1;
          tx_cmd.consume = 1'b1;
        end
        dbfifo_pkg::OP_CLEAR_RX: rx_cmd.clear = 1'b1;
        dbfifo_pkg::OP_CLEAR_TX: tx_cmd.clear = 1'b1;
        dbfifo_pkg::OP_CLEAR_ALL: begin
          rx_cmd.clear     = 1'b1;
          rx_cmd.clear_cnt = 1'b1;
          tx_cmd.clear     = 1'b1;
          tx_cmd.clear_cnt = 1'b1;
        end
        default: begin
          rx_cmd = '0;
          tx_cmd = '0;
        end
      endcase
    end
  end

  dbfifo_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (rx_cmd),
    .data_i    (data_byte_i),
    .take_ok_o (rx_take_ok),
    .rdata_o   (rx_rdata),
    .stat_o    (rx_stat)
  );

  dbfifo_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tx_cmd),
    .data_i    (data_byte_i),
    .take_ok_o (tx_take_ok),
    .rdata_o   (tx_rdata),
    .stat_o    (tx_stat)
  );

  // Ring state only changes on accept, so while a transaction sits in the work
  // stage the ring status reflects exactly that transaction.
  always_comb begin
    work_valid_d = work_valid_q;
    if (accept) begin
      work_valid_d = 1'b1;
    end else if (move) begin
      work_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_rd_q <= rx_take_ok || tx_take_ok;
      work_tx_q <= tx_take_ok;
    end
    if (move) begin
      read_valid_o <= work_rd_q;
      read_data_o  <= !work_rd_q ? '0 : (work_tx_q ? tx_rdata : rx_rdata);
      rx_level_o   <= rx_stat.level;
      tx_level_o   <= tx_stat.level;
      rx_pushed_o  <= rx_stat.pushed;
      rx_dropped_o <= rx_stat.dropped;
      tx_pushed_o  <= tx_stat.pushed;
      tx_dropped_o <= tx_stat.dropped;
    end
  end

  assign out_valid_o = out_valid_q;

  // A stalled input side always means a transaction is held in the work stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> work_valid_q)
    else $error("input stalled with empty work stage");

  // A result without a byte carries zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == '0)
    else $error("nonzero data on a result without a byte");

  // A receive push advances the receive push counter by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == dbfifo_pkg::OP_PUSH_RX
      |=> rx_stat.pushed == $past(rx_stat.pushed) + dbfifo_pkg::CountW'(1))
    else $error("receive push counter did not advance");

  // Reading an empty receive ring leaves it empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == dbfifo_pkg::OP_READ_RX && rx_stat.level == '0
      |=> rx_stat.level == '0 && !work_rd_q)
    else $error("read of empty receive ring changed state");

endmodule

`default_nettype wire

### sv/dbfifo_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module dbfifo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/dbfifo_ring.sv
// One drop-oldest byte ring: head/tail pointers, push/drop counters, store RAM.
// Depends on dbfifo_pkg and dbfifo_ram.
`default_nettype none

module dbfifo_ring #(
  parameter int unsigned DEPTH = dbfifo_pkg::DefDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dbfifo_pkg::ring_cmd_t           cmd_i,
  input  wire logic [dbfifo_pkg::ByteW-1:0]    data_i,
  output logic                                 take_ok_o,
  output logic      [dbfifo_pkg::ByteW-1:0]    rdata_o,
  output dbfifo_pkg::ring_stat_t               stat_o
);

  localparam int unsigned Cap   = (DEPTH < dbfifo_pkg::MinDepth) ? dbfifo_pkg::MinDepth : DEPTH;
  localparam int unsigned PtrW  = $clog2(Cap);
  localparam int unsigned WideW = (PtrW + 1 > dbfifo_pkg::LevelW) ? PtrW + 1
                                                                  : dbfifo_pkg::LevelW;

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [PtrW-1:0] head_inc, tail_inc;
  logic [dbfifo_pkg::CountW-1:0] pushed_q, pushed_d, dropped_q, dropped_d;
  logic            full, empty, ram_we, ram_re;
  logic [WideW-1:0] level_w;

  assign head_inc = (head_q == PtrW'(Cap - 1)) ? '0 : head_q + PtrW'(1);
  assign tail_inc = (tail_q == PtrW'(Cap - 1)) ? '0 : tail_q + PtrW'(1);
  assign full     = (head_inc == tail_q);
  assign empty    = (head_q == tail_q);

  assign ram_we    = cmd_i.push;
  assign ram_re    = cmd_i.take && !empty;
  assign take_ok_o = ram_re;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    pushed_d  = pushed_q;
    dropped_d = dropped_q;
    if (cmd_i.push) begin
      head_d   = head_inc;
      pushed_d = pushed_q + dbfifo_pkg::CountW'(1);
      if (full) begin
        // oldest byte gives way
        tail_d    = tail_inc;
        dropped_d = dropped_q + dbfifo_pkg::CountW'(1);
      end
    end
    if (ram_re && cmd_i.consume) begin
      tail_d = tail_inc;
    end
    if (cmd_i.clear) begin
      head_d = '0;
      tail_d = '0;
    end
    if (cmd_i.clear_cnt) begin
      pushed_d  = '0;
      dropped_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      pushed_q  <= '0;
      dropped_q <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      pushed_q  <= pushed_d;
      dropped_q <= dropped_d;
    end
  end

  dbfifo_ram #(
    .WIDTH (dbfifo_pkg::ByteW),
    .DEPTH (Cap)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (data_i),
    .re_i    (ram_re),
    .raddr_i (tail_q),
    .rdata_o (rdata_o)
  );

  // Fill level, saturated to the 8-bit field.
  assign level_w = (head_q >= tail_q) ? (WideW'(head_q) - WideW'(tail_q))
                                      : (WideW'(Cap) - (WideW'(tail_q) - WideW'(head_q)));

  assign stat_o.level   = (level_w > WideW'(255)) ? dbfifo_pkg::LevelW'(255)
                                                  : level_w[dbfifo_pkg::LevelW-1:0];
  assign stat_o.pushed  = pushed_q;
  assign stat_o.dropped = dropped_q;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for dual_byte_fifo_drop_oldest_top (receive and transmit rings).
// Depends on dbfifo_pkg and the RTL of the block. Predicts every status transaction
// and checks it in order, with random idling, backpressure and overflow phases.
`default_nettype none

module tb_top;
  import dbfifo_pkg::*;

  // Ring capacity in slots, after the minimum-depth rule; holds capacity-1 bytes.
  localparam int unsigned RxCap       = (DefDepth < MinDepth) ? MinDepth : DefDepth;
  localparam int unsigned TxCap       = (DefDepth < MinDepth) ? MinDepth : DefDepth;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned StallCycles = 80;

  // Operation mixes for the random phases.
  typedef enum int {
    MIX_RX_FILL,
    MIX_TX_FILL,
    MIX_ANY
  } op_mix_e;

  // One status transaction as the block reports it.
  typedef struct packed {
    logic              rd_valid;
    logic [ByteW-1:0]  rd_data;
    logic [LevelW-1:0] rx_lvl;
    logic [LevelW-1:0] tx_lvl;
    logic [CountW-1:0] rx_push;
    logic [CountW-1:0] rx_drop;
    logic [CountW-1:0] tx_push;
    logic [CountW-1:0] tx_drop;
  } fifo_status_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [OpW-1:0]    operation_i;
  logic [ByteW-1:0]  data_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              read_valid_o;
  logic [ByteW-1:0]  read_data_o;
  logic [LevelW-1:0] rx_level_o;
  logic [LevelW-1:0] tx_level_o;
  logic [CountW-1:0] rx_pushed_o;
  logic [CountW-1:0] rx_dropped_o;
  logic [CountW-1:0] tx_pushed_o;
  logic [CountW-1:0] tx_dropped_o;

  dual_byte_fifo_drop_oldest_top #(
    .RX_DEPTH(DefDepth),
    .TX_DEPTH(DefDepth)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_valid_o(read_valid_o),
    .read_data_o (read_data_o),
    .rx_level_o  (rx_level_o),
    .tx_level_o  (tx_level_o),
    .rx_pushed_o (rx_pushed_o),
    .rx_dropped_o(rx_dropped_o),
    .tx_pushed_o (tx_pushed_o),
    .tx_dropped_o(tx_dropped_o)
  );

  // ---------------------------------------------------------------------------
  // Ring shadow state. Pointers are kept modulo capacity, the counters wrap on
  // their own at 32 bits. Slots are only read once written, as in the block.
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0]  rx_mem [RxCap];
  logic [ByteW-1:0]  tx_mem [TxCap];
  int unsigned       rx_wr = 0, rx_rd = 0, tx_wr = 0, tx_rd = 0;
  logic [CountW-1:0] rx_push_cnt = '0, rx_drop_cnt = '0;
  logic [CountW-1:0] tx_push_cnt = '0, tx_drop_cnt = '0;

  // Status transactions predicted at input acceptance, oldest first.
  fifo_status_t      status_q[$];

  int unsigned       err_cnt   = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       idle_pct  = 7;   // per-cycle chance (percent) of a bubble, both sides
  logic              stall_toggle = 1'b0;  // flipped by a test to request a long hold-off

  // Fill level, saturated to the 8-bit field.
  function automatic logic [LevelW-1:0] level_of(int unsigned cap, int unsigned wr,
                                                 int unsigned rd);
    int unsigned n;
    n = (wr >= rd) ? (wr - rd) : (cap - (rd - wr));
    return (n > 255) ? 8'hFF : LevelW'(n);
  endfunction

  // Apply one operation to the shadow rings and return the status it yields.
  function automatic fifo_status_t step_rings(input logic [OpW-1:0] op,
                                              input logic [ByteW-1:0] b);
    fifo_status_t s;
    int unsigned  nxt;
    s = '0;
    case (op)
      OP_PUSH_RX: begin
        nxt = (rx_wr + 1) % RxCap;
        // full ring: the oldest byte goes first
        if (nxt == rx_rd) begin
          rx_rd = (rx_rd + 1) % RxCap;
          rx_drop_cnt++;
        end
        rx_mem[rx_wr] = b;
        rx_wr = nxt;
        rx_push_cnt++;
      end
      OP_PUSH_TX: begin
        nxt = (tx_wr + 1) % TxCap;
        if (nxt == tx_rd) begin
          tx_rd = (tx_rd + 1) % TxCap;
          tx_drop_cnt++;
        end
        tx_mem[tx_wr] = b;
        tx_wr = nxt;
        tx_push_cnt++;
      end
      OP_READ_RX, OP_PEEK_RX: begin
        if (rx_rd != rx_wr) begin
          s.rd_valid = 1'b1;
          s.rd_data  = rx_mem[rx_rd];
          if (op == OP_READ_RX) rx_rd = (rx_rd + 1) % RxCap;
        end
      end
      OP_READ_TX: begin
        if (tx_rd != tx_wr) begin
          s.rd_valid = 1'b1;
          s.rd_data  = tx_mem[tx_rd];
          tx_rd = (tx_rd + 1) % TxCap;
        end
      end
      OP_CLEAR_RX: begin
        rx_wr = 0;
        rx_rd = 0;
      end
      OP_CLEAR_TX: begin
        tx_wr = 0;
        tx_rd = 0;
      end
      default: begin
        // clear-all: pointers and counters
        rx_wr = 0;
        rx_rd = 0;
        tx_wr = 0;
        tx_rd = 0;
        rx_push_cnt = '0;
        rx_drop_cnt = '0;
        tx_push_cnt = '0;
        tx_drop_cnt = '0;
      end
    endcase
    s.rx_lvl  = level_of(RxCap, rx_wr, rx_rd);
    s.tx_lvl  = level_of(TxCap, tx_wr, tx_rd);
    s.rx_push = rx_push_cnt;
    s.rx_drop = rx_drop_cnt;
    s.tx_push = tx_push_cnt;
    s.tx_drop = tx_drop_cnt;
    return s;
  endfunction

  // Weighted operation pick. Fill mixes are mostly pushes into one ring so it
  // reaches full and wraps; the open mix exercises everything, clears included.
  function automatic logic [OpW-1:0] pick_op(op_mix_e mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      MIX_RX_FILL: begin
        if (r < 92)      return OP_PUSH_RX;
        else if (r < 96) return OP_PEEK_RX;
        else if (r < 98) return OP_READ_RX;
        else             return OP_PUSH_TX;
      end
      MIX_TX_FILL: begin
        if (r < 92)      return OP_PUSH_TX;
        else if (r < 96) return OP_READ_TX;
        else if (r < 98) return OP_PEEK_RX;
        else             return OP_PUSH_RX;
      end
      default: begin
        if (r < 24)      return OP_PUSH_RX;
        else if (r < 48) return OP_PUSH_TX;
        else if (r < 62) return OP_READ_RX;
        else if (r < 72) return OP_PEEK_RX;
        else if (r < 86) return OP_READ_TX;
        else if (r < 90) return OP_CLEAR_RX;
        else if (r < 94) return OP_CLEAR_TX;
        else             return OP_CLEAR_ALL;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is asserted once and released on an edge by a
  // nonblocking write so sampling at that edge still sees it low.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_PUSH_RX;
    data_byte_i = '0;
    out_ready_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Called at a rising edge; returns at the edge where the
  // transaction was taken, with valid still high so a back-to-back transaction
  // can follow without a bubble. Bubbles drop valid for whole cycles.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [OpW-1:0] op, input logic [ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    status_q.push_back(step_rings(op, b));
  endtask

  // ---------------------------------------------------------------------------
  // Output side: checks every accepted status transaction against the oldest
  // prediction, then decides ready for the next cycle. A flip of stall_toggle
  // starts a long hold-off counted here, so the block backs up to its input.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : status_sink
    fifo_status_t want;
    int unsigned  hold_left;
    logic         stall_seen;
    if (!rst_ni) begin
      hold_left  = 0;
      stall_seen = stall_toggle;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          $display("%0t: status transaction with none predicted", $time);
          err_cnt++;
        end else begin
          want = status_q.pop_front();
          check_field("read_valid", CountW'(want.rd_valid), CountW'(read_valid_o));
          check_field("read_data",  CountW'(want.rd_data),  CountW'(read_data_o));
          check_field("rx_level",   CountW'(want.rx_lvl),   CountW'(rx_level_o));
          check_field("tx_level",   CountW'(want.tx_lvl),   CountW'(tx_level_o));
          check_field("rx_pushed",  want.rx_push, rx_pushed_o);
          check_field("rx_dropped", want.rx_drop, rx_dropped_o);
          check_field("tx_pushed",  want.tx_push, tx_pushed_o);
          check_field("tx_dropped", want.tx_drop, tx_dropped_o);
        end
      end
      if (stall_toggle != stall_seen) begin
        stall_seen = stall_toggle;
        hold_left  = StallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty reads, extreme bytes, every operation, ignored data on non-push
  // operations, clears that keep the counters, and a slot rewritten after clear.
  task automatic test_directed();
    send_op(OP_READ_RX,   8'hFF);   // empty ring
    send_op(OP_PEEK_RX,   8'hFF);
    send_op(OP_READ_TX,   8'hFF);
    send_op(OP_PUSH_RX,   8'h00);
    send_op(OP_PUSH_RX,   8'hFF);
    send_op(OP_PEEK_RX,   8'h55);   // peek does not consume
    send_op(OP_READ_RX,   8'hAA);
    send_op(OP_READ_RX,   8'h00);
    send_op(OP_READ_RX,   8'h00);   // empty again
    send_op(OP_PUSH_TX,   8'hA5);
    send_op(OP_PUSH_TX,   8'h5A);
    send_op(OP_READ_TX,   8'h00);
    send_op(OP_PUSH_RX,   8'h3C);
    send_op(OP_CLEAR_RX,  8'hFF);   // pointers only, counters stay
    send_op(OP_READ_RX,   8'h00);
    send_op(OP_PUSH_RX,   8'h81);
    send_op(OP_PEEK_RX,   8'h00);
    send_op(OP_CLEAR_TX,  8'hFF);
    send_op(OP_READ_TX,   8'h00);
    send_op(OP_CLEAR_ALL, 8'hFF);   // counters back to zero
    send_op(OP_PUSH_TX,   8'h7E);
    send_op(OP_READ_TX,   8'h00);
  endtask

  // Mostly receive pushes: the ring fills, wraps and starts dropping.
  task automatic test_rx_overflow();
    repeat (300) send_op(pick_op(MIX_RX_FILL), 8'($urandom));
  endtask

  // Same for the transmit ring, run without any idling on either side.
  task automatic test_tx_overflow();
    idle_pct = 0;
    repeat (300) send_op(pick_op(MIX_TX_FILL), 8'($urandom));
    idle_pct = 7;
  endtask

  // Receiver holds off for a long stretch while transactions keep coming.
  task automatic test_output_stall();
    stall_toggle <= ~stall_toggle;
    repeat (30) send_op(pick_op(MIX_ANY), 8'($urandom));
  endtask

  // Open mix of all operations with random bytes.
  task automatic test_random_mix();
    repeat (220) send_op(pick_op(MIX_ANY), 8'($urandom));
  endtask

  initial begin : main_seq
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rx_overflow();
    test_tx_overflow();
    test_output_stall();
    test_random_mix();
    in_valid_i <= 1'b0;

    // let the last status transactions come out, then watch for strays
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
